// ----- hw/rtl/ring_switch_route_arbiter_top_defines.svh -----
// ----------------------------------------------------------------------------
// ring switch route arbiter assertion macros
// concurrent assertion helpers clocked on aclk, quiet while aresetn is low
// ----------------------------------------------------------------------------
`ifndef RING_SWITCH_ROUTE_ARBITER_TOP_DEFINES_SVH
`define RING_SWITCH_ROUTE_ARBITER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define RSRA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// condition must never be true out of reset
`define RSRA_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define RSRA_ASSERT(label, prop, msg)
`define RSRA_NEVER(label, cond, msg)
`endif

`endif

// ----- hw/rtl/rsra_pkg.sv -----
// ----------------------------------------------------------------------------
// rsra_pkg
// shared types, codes and routing function of the ring switch route arbiter
// ----------------------------------------------------------------------------
`default_nettype none

package rsra_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PORT_COUNT      = 4;
    localparam int NODE_W          = 6;
    localparam int ID_W            = 32;
    localparam int ENTRY_W         = 2 * NODE_W + ID_W;

    typedef logic [1:0]        port_t;
    typedef logic [2:0]        status_t;
    typedef logic [NODE_W-1:0] node_t;

    localparam port_t PORT_NORTH = 2'd0;
    localparam port_t PORT_EAST  = 2'd1;
    localparam port_t PORT_SOUTH = 2'd2;
    localparam port_t PORT_WEST  = 2'd3;

    localparam status_t STAT_ACCEPTED   = 3'd0;
    localparam status_t STAT_REJECTED   = 3'd1;
    localparam status_t STAT_FORWARDED  = 3'd2;
    localparam status_t STAT_STALLED    = 3'd3;
    localparam status_t STAT_IDLE       = 3'd4;
    localparam status_t STAT_UNROUTABLE = 3'd5;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_SERVICE = 1'b1;

    localparam logic REG_OWN_NODE    = 1'b0;
    localparam logic REG_MEDIAN_HOPS = 1'b1;

    localparam node_t OWN_NODE_RST    = 6'd1;
    localparam node_t MEDIAN_HOPS_RST = 6'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic  drop;
        port_t target;
    } route_t;

    // floor(x / 3) for x below 128, by reciprocal multiply
    function automatic logic [5:0] div3(input logic [6:0] x);
        logic [15:0] prod;
        prod = 16'(x) * 16'd171;
        return prod[14:9];
    endfunction

    function automatic logic [1:0] mod3(input node_t x);
        logic [5:0] q;
        logic [7:0] back;
        q    = div3({1'b0, x});
        back = 8'(q) * 8'd3;
        return 2'(8'(x) - back);
    endfunction

    // ring distance in steps of three node ids
    function automatic node_t ring_dist(input node_t d, input node_t s);
        logic       d_mod0;
        logic       s_mod0;
        logic [6:0] diff;
        d_mod0 = (mod3(d) == 2'd0);
        s_mod0 = (mod3(s) == 2'd0);
        if (d > s) begin
            diff = {1'b0, d} - {1'b0, s};
            if (!d_mod0 && s_mod0) begin
                return (diff < 7'd2) ? node_t'(0) : div3(diff - 7'd2);
            end
            return div3(diff);
        end
        if (s_mod0 && !d_mod0) begin
            return div3({1'b0, s} + 7'd2 - {1'b0, d});
        end
        return div3({1'b0, s} - {1'b0, d});
    endfunction

    function automatic route_t route_head(input port_t from, input node_t s,
                                          input node_t d, input node_t n,
                                          input node_t median);
        route_t r;
        logic   near;
        r.drop   = 1'b0;
        r.target = PORT_NORTH;
        near     = (ring_dist(d, s) <= median);
        if (({1'b0, d} + 7'd1) == {1'b0, n}) begin
            r.target = PORT_NORTH;
        end else if ({1'b0, d} == ({1'b0, n} + 7'd1)) begin
            r.target = PORT_SOUTH;
        end else if (from == PORT_EAST) begin
            r.target = PORT_WEST;
        end else if (from == PORT_WEST) begin
            r.target = PORT_EAST;
        end else if (d > s) begin
            r.target = near ? PORT_EAST : PORT_WEST;
        end else if (s > d) begin
            r.target = near ? PORT_WEST : PORT_EAST;
        end else begin
            r.drop = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rsra_ctrl.sv -----
// ----------------------------------------------------------------------------
// rsra_ctrl
// sequencer: accept a transaction, read the queue memory, then commit
// ----------------------------------------------------------------------------
`default_nettype none
`include "ring_switch_route_arbiter_top_defines.svh"

module rsra_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    output rsra_pkg::dp_cmd_t       cmd,
    input  wire rsra_pkg::dp_stat_t stat
);
    import rsra_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                // nothing is taken while reset is held
                s_axis_tready = aresetn;
                if (s_axis_tvalid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.issue  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                // wait for the result register to drain
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `RSRA_ASSERT(a_issue_then_exec, (state_reg == ST_ISSUE) |=> (state_reg == ST_EXEC), "issue not followed by exec")
    `RSRA_ASSERT(a_accept_goes_issue, (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_ISSUE), "accepted transaction not issued")

endmodule

`default_nettype wire

// ----- hw/rtl/rsra_dp.sv -----
// ----------------------------------------------------------------------------
// rsra_dp
// port queues, round robin pick, routing decision and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "ring_switch_route_arbiter_top_defines.svh"

module rsra_dp #(
    parameter int QUEUE_DEPTH = rsra_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire rsra_pkg::dp_cmd_t     cmd,
    output rsra_pkg::dp_stat_t         stat,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [5:0]            cfg_wdata,
    input  wire logic [55:0]           s_axis_tdata,
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [47:0]                m_axis_tdata,
    output logic [2:0]                 m_axis_tuser
);
    import rsra_pkg::*;

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W    = 2 + PTR_W;
    localparam int MEM_DEPTH = PORT_COUNT << PTR_W;

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

    // configuration
    node_t own_node_reg;
    node_t median_reg;

    // queue control
    logic [FILL_W-1:0] fill_reg [PORT_COUNT];
    logic [PTR_W-1:0]  head_reg [PORT_COUNT];
    logic [PTR_W-1:0]  tail_reg [PORT_COUNT];
    port_t             last_served_reg;

    // queue storage
    logic [ENTRY_W-1:0] mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // captured transaction
    logic          action_reg;
    port_t         port_reg;
    node_t         src_reg;
    node_t         dest_reg;
    logic [ID_W-1:0] id_reg;
    logic [3:0]    rdy_reg;

    // arbiter
    port_t pick;
    logic  found;
    port_t pick_reg;
    logic  found_reg;

    // result register
    logic          m_valid_reg;
    status_t       res_status_reg;
    port_t         res_out_port_reg;
    port_t         res_from_reg;
    node_t         res_src_reg;
    node_t         res_dest_reg;
    logic [ID_W-1:0] res_id_reg;

    status_t       res_status_next;
    port_t         res_out_port_next;
    port_t         res_from_next;
    node_t         res_src_next;
    node_t         res_dest_next;
    logic [ID_W-1:0] res_id_next;

    logic          do_push;
    logic          do_pop;
    logic          upd_last;
    logic          out_free;
    node_t         head_src;
    node_t         head_dest;
    logic [ID_W-1:0] head_id;
    route_t        rt;
    logic          fill_ok;
    logic          empty_ok;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign stat.out_free = out_free;

    assign head_src  = rd_data_reg[ENTRY_W-1 -: NODE_W];
    assign head_dest = rd_data_reg[ID_W +: NODE_W];
    assign head_id   = rd_data_reg[ID_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_node_reg <= OWN_NODE_RST;
            median_reg   <= MEDIAN_HOPS_RST;
        end else if (cfg_we) begin
            if (cfg_index == REG_OWN_NODE) begin
                own_node_reg <= cfg_wdata;
            end else begin
                median_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= s_axis_tuser;
            port_reg   <= s_axis_tdata[1:0];
            src_reg    <= s_axis_tdata[7:2];
            dest_reg   <= s_axis_tdata[13:8];
            id_reg     <= s_axis_tdata[45:14];
            rdy_reg    <= s_axis_tdata[49:46];
        end
    end

    // first non-empty port after the last one served
    always_comb begin
        port_t idx;
        pick  = last_served_reg;
        found = 1'b0;
        for (int k = PORT_COUNT; k >= 1; k--) begin
            idx = last_served_reg + 2'(k);
            if (fill_reg[idx] != '0) begin
                pick  = idx;
                found = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            pick_reg    <= pick;
            found_reg   <= found;
            rd_data_reg <= mem[ADDR_W'({pick, head_reg[pick]})];
        end
        if (do_push) begin
            mem[ADDR_W'({port_reg, tail_reg[port_reg]})] <= {src_reg, dest_reg, id_reg};
        end
    end

    assign rt = route_head(pick_reg, head_src, head_dest, own_node_reg, median_reg);

    always_comb begin
        do_push           = 1'b0;
        do_pop            = 1'b0;
        upd_last          = 1'b0;
        res_status_next   = STAT_IDLE;
        res_out_port_next = PORT_NORTH;
        res_from_next     = PORT_NORTH;
        res_src_next      = '0;
        res_dest_next     = '0;
        res_id_next       = '0;
        if (action_reg == ACT_ENQUEUE) begin
            res_from_next = port_reg;
            res_src_next  = src_reg;
            res_dest_next = dest_reg;
            res_id_next   = id_reg;
            if (fill_reg[port_reg] >= FILL_MAX) begin
                res_status_next = STAT_REJECTED;
            end else begin
                res_status_next = STAT_ACCEPTED;
                do_push         = cmd.commit;
            end
        end else if (found_reg) begin
            upd_last      = cmd.commit;
            res_from_next = pick_reg;
            res_src_next  = head_src;
            res_dest_next = head_dest;
            res_id_next   = head_id;
            if (rt.drop) begin
                res_status_next = STAT_UNROUTABLE;
                do_pop          = cmd.commit;
            end else if (!rdy_reg[rt.target]) begin
                res_status_next   = STAT_STALLED;
                res_out_port_next = rt.target;
            end else begin
                res_status_next   = STAT_FORWARDED;
                res_out_port_next = rt.target;
                do_pop            = cmd.commit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PORT_COUNT; i++) begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            last_served_reg <= PORT_NORTH;
        end else begin
            if (upd_last) begin
                last_served_reg <= pick_reg;
            end
            if (do_push) begin
                fill_reg[port_reg] <= fill_reg[port_reg] + 1'b1;
                tail_reg[port_reg] <= (tail_reg[port_reg] == PTR_LAST) ? '0
                                    : tail_reg[port_reg] + 1'b1;
            end
            if (do_pop) begin
                fill_reg[pick_reg] <= fill_reg[pick_reg] - 1'b1;
                head_reg[pick_reg] <= (head_reg[pick_reg] == PTR_LAST) ? '0
                                    : head_reg[pick_reg] + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            res_status_reg   <= res_status_next;
            res_out_port_reg <= res_out_port_next;
            res_from_reg     <= res_from_next;
            res_src_reg      <= res_src_next;
            res_dest_reg     <= res_dest_next;
            res_id_reg       <= res_id_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = res_status_reg;
    assign m_axis_tdata  = {res_id_reg, res_dest_reg, res_src_reg,
                            res_from_reg, res_out_port_reg};

    always_comb begin
        fill_ok  = 1'b1;
        empty_ok = 1'b1;
        for (int i = 0; i < PORT_COUNT; i++) begin
            if (fill_reg[i] > FILL_MAX) begin
                fill_ok = 1'b0;
            end
            if (fill_reg[i] == '0 && head_reg[i] != tail_reg[i]) begin
                empty_ok = 1'b0;
            end
        end
    end

    `RSRA_ASSERT(a_fill_bound, fill_ok, "queue fill above depth")
    `RSRA_ASSERT(a_empty_ptrs, empty_ok, "empty queue with head and tail apart")
    `RSRA_NEVER(a_commit_blocked, cmd.commit && !out_free, "result overwritten before taken")
    `RSRA_ASSERT(a_commit_shows, cmd.commit |=> m_valid_reg, "committed result not presented")

endmodule

`default_nettype wire

// ----- hw/rtl/ring_switch_route_arbiter_top.sv -----
// ----------------------------------------------------------------------------
// ring_switch_route_arbiter_top
// one ring switch: four input queues, round robin service, route selection
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one transaction per item: tuser selects enqueue (0) or
//   service (1); tdata holds the arriving packet and the four ready flags
//   m_axis returns exactly one result transaction per accepted item, in order,
//   tuser is the status code and tdata the routed packet fields
//   cfg_we/cfg_index/cfg_wdata write own_node (index 0) or median_hops
//   (index 1) while the switch is idle
// sequence
//   an item is accepted in IDLE, its queue head is read from the queue memory
//   into a register in ISSUE and the result is committed in EXEC once the
//   output register is free; m_axis_tvalid is registered from the commit and
//   a new item is taken only after the last one has been committed
// reset
//   aresetn low clears all queues, pointers, round robin position (north)
//   and the result valid; own_node returns to 1 and median_hops to 2
// stall
//   a waiting result stays in the output register; one further item is
//   accepted and held at its commit step until the output register drains
// ----------------------------------------------------------------------------
`default_nettype none

module ring_switch_route_arbiter_top #(
    parameter int QUEUE_DEPTH = rsra_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [5:0]  cfg_wdata,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // in_port[1:0] pkt_src[7:2] pkt_dest[13:8] packet_id[45:14]
    // ready_north[46] ready_east[47] ready_south[48] ready_west[49] zero[55:50]
    input  wire logic [55:0] s_axis_tdata,
    // action[0]
    input  wire logic        s_axis_tuser,
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_port[1:0] from_port[3:2] out_src[9:4] out_dest[15:10] out_id[47:16]
    output logic [47:0]      m_axis_tdata,
    // status[2:0]
    output logic [2:0]       m_axis_tuser
);
    import rsra_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    rsra_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cmd           (cmd),
        .stat          (stat)
    );

    // queues, arbiter, routing and result register
    rsra_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
